/* hdl/fskv_pkg.sv */
// Package for the fixed-slot key/value table: sizes, codes, beat structs
// and the byte helpers for zero-terminated packed strings.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fskv_pkg;

    localparam int SLOTS       = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = 5;

    typedef logic [63:0] t_word;

    typedef enum logic [2:0] {
        FN_SET     = 3'd0,
        FN_GET     = 3'd1,
        FN_DELETE  = 3'd2,
        FN_CLEAR   = 3'd3,
        FN_ITERATE = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_TOO_SMALL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ITER
    } t_state;

    typedef struct packed {
        logic [2:0] func;
        t_word      key;
        t_word      value;
        logic [7:0] buf_size;
    } t_cmd;

    typedef struct packed {
        logic [2:0]       status;
        logic             entry_valid;
        t_word            out_key;
        t_word            ret_value;
        logic [CNT_W-1:0] live_count;
        logic             last;
    } t_result;

    // Bytes before the first zero within nbytes; nbytes if none.
    function automatic logic [3:0] packed_len(t_word w, int nbytes);
        logic [3:0] len;
        logic       found;
        len   = 4'(nbytes);
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes && !found && w[8*i +: 8] == 8'd0) begin
                len   = 4'(i);
                found = 1'b1;
            end
        end
        return len;
    endfunction

    // Clears the first zero byte onward and everything past nbytes.
    function automatic t_word keep_bytes(t_word w, int nbytes);
        t_word r;
        logic  stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= nbytes || w[8*i +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            r[8*i +: 8] = stop ? 8'd0 : w[8*i +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/fixed_slot_key_value_table_core.sv */
// Fixed-slot key/value table core: command decode, slot scan over the key
// and value memories, and result beat generation. Uses fskv_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive i_cmd and raise start; the beat is taken at the
//   edge where start is high and busy is low. Result channel: o_valid marks
//   a one-cycle beat on o_result; the receiver cannot hold it off.
//   Set, get and delete walk the slots in order, one memory read per cycle
//   with the compare in the cycle after each read, stopping at the first
//   key match; busy drops in the same cycle as the result appears. Set of
//   a new key always walks the whole table.
//   Invalid commands, clear and iterate of an empty table answer in the
//   cycle after the command beat without going busy.
//   Iterate streams one beat per used slot, one slot per cycle once the
//   first slot read returns, with last on the final beat. The scan rate is
//   set by the single read port of the memories.
//   Reset clears the slot used bits and the live count; memory contents
//   of an unused slot are never used, so no clearing pass is needed.
module fixed_slot_key_value_table_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  wire fskv_pkg::t_cmd i_cmd,
    output logic             busy,
    output logic             o_valid,
    output fskv_pkg::t_result o_result
);

    localparam logic [fskv_pkg::IDX_W-1:0] LAST_IDX = fskv_pkg::IDX_W'(fskv_pkg::SLOTS - 1);

    fskv_pkg::t_word mem_key [fskv_pkg::SLOTS];
    fskv_pkg::t_word mem_val [fskv_pkg::SLOTS];

    fskv_pkg::t_state              r_state, n_state;
    logic [fskv_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [fskv_pkg::IDX_W-1:0]    r_rd_idx;
    logic                          r_rd_vld;
    logic                          r_issue, n_issue;
    logic [2:0]                    r_func, n_func;
    fskv_pkg::t_word               r_key, n_key;
    fskv_pkg::t_word               r_value, n_value;
    logic [7:0]                    r_osize, n_osize;
    logic [fskv_pkg::SLOTS-1:0]    r_used, n_used;
    logic [fskv_pkg::CNT_W-1:0]    r_count, n_count;
    logic                          r_free_vld, n_free_vld;
    logic [fskv_pkg::IDX_W-1:0]    r_free_idx, n_free_idx;
    logic                          r_valid, n_valid;
    fskv_pkg::t_result             r_res, n_res;
    fskv_pkg::t_word               r_q_key, r_q_val;

    logic                          issuing;
    logic                          mem_we_key, mem_we_val;
    logic [fskv_pkg::IDX_W-1:0]    mem_wa;
    fskv_pkg::t_word               mem_wkey, mem_wval;

    logic                          key_ok, val_ok, hit, done, slot_free, more_used;
    logic [fskv_pkg::SLOTS-1:0]    above;

    assign key_ok = fskv_pkg::packed_len(i_cmd.key, fskv_pkg::KEY_BYTES)
                    < 4'(fskv_pkg::KEY_BYTES);
    assign val_ok = fskv_pkg::packed_len(i_cmd.value, fskv_pkg::VALUE_BYTES)
                    < 4'(fskv_pkg::VALUE_BYTES);

    assign hit       = r_rd_vld && r_used[r_rd_idx] && (r_q_key == r_key);
    assign slot_free = r_rd_vld && !r_used[r_rd_idx];
    assign done      = r_rd_vld && (hit || r_rd_idx == LAST_IDX);

    always_comb begin
        for (int j = 0; j < fskv_pkg::SLOTS; j++) begin
            above[j] = (fskv_pkg::IDX_W'(j) > r_rd_idx);
        end
    end
    assign more_used = |(r_used & above);

    assign busy     = (r_state != fskv_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // Slot memories: one read port, one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we_key) begin
            mem_key[mem_wa] <= mem_wkey;
        end
        if (mem_we_val) begin
            mem_val[mem_wa] <= mem_wval;
        end
        r_q_key <= mem_key[r_idx];
        r_q_val <= mem_val[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fskv_pkg::S_IDLE;
            r_used     <= '0;
            r_count    <= '0;
            r_valid    <= 1'b0;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_count    <= n_count;
            r_valid    <= n_valid;
            r_issue    <= n_issue;
            r_rd_vld   <= issuing;
            r_free_vld <= n_free_vld;
        end
        r_idx      <= n_idx;
        r_rd_idx   <= r_idx;
        r_func     <= n_func;
        r_key      <= n_key;
        r_value    <= n_value;
        r_osize    <= n_osize;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_issue    = r_issue;
        n_func     = r_func;
        n_key      = r_key;
        n_value    = r_value;
        n_osize    = r_osize;
        n_used     = r_used;
        n_count    = r_count;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_valid    = 1'b0;
        n_res      = r_res;
        issuing    = 1'b0;
        mem_we_key = 1'b0;
        mem_we_val = 1'b0;
        mem_wa     = r_rd_idx;
        mem_wkey   = r_key;
        mem_wval   = r_value;

        // Single-beat result template.
        n_res.entry_valid = 1'b0;
        n_res.out_key     = '0;
        n_res.ret_value   = '0;
        n_res.last        = 1'b1;
        n_res.status      = fskv_pkg::ST_OK;

        unique case (r_state)
            fskv_pkg::S_IDLE: begin
                if (start) begin
                    n_func     = i_cmd.func;
                    n_key      = fskv_pkg::keep_bytes(i_cmd.key, fskv_pkg::KEY_BYTES);
                    n_value    = fskv_pkg::keep_bytes(i_cmd.value, fskv_pkg::VALUE_BYTES);
                    n_osize    = i_cmd.buf_size;
                    n_idx      = '0;
                    n_free_vld = 1'b0;
                    unique case (i_cmd.func)
                        fskv_pkg::FN_SET: begin
                            if (!key_ok || !val_ok) begin
                                n_valid      = 1'b1;
                                n_res.status = fskv_pkg::ST_INVALID;
                            end else begin
                                n_state = fskv_pkg::S_SCAN;
                                n_issue = 1'b1;
                            end
                        end
                        fskv_pkg::FN_GET: begin
                            if (!key_ok || i_cmd.buf_size == 8'd0) begin
                                n_valid      = 1'b1;
                                n_res.status = fskv_pkg::ST_INVALID;
                            end else begin
                                n_state = fskv_pkg::S_SCAN;
                                n_issue = 1'b1;
                            end
                        end
                        fskv_pkg::FN_DELETE: begin
                            if (!key_ok) begin
                                n_valid      = 1'b1;
                                n_res.status = fskv_pkg::ST_INVALID;
                            end else begin
                                n_state = fskv_pkg::S_SCAN;
                                n_issue = 1'b1;
                            end
                        end
                        fskv_pkg::FN_CLEAR: begin
                            n_used  = '0;
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        fskv_pkg::FN_ITERATE: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = fskv_pkg::S_ITER;
                                n_issue = 1'b1;
                            end
                        end
                        default: begin
                            n_valid      = 1'b1;
                            n_res.status = fskv_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            fskv_pkg::S_SCAN: begin
                issuing = r_issue && !done;
                if (issuing) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                // lowest free slot seen so far
                if (slot_free && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free_idx = r_rd_idx;
                end
                if (done) begin
                    n_state = fskv_pkg::S_IDLE;
                    n_issue = 1'b0;
                    n_valid = 1'b1;
                    case (r_func)
                        fskv_pkg::FN_SET: begin
                            if (hit) begin
                                mem_we_val = 1'b1;
                                mem_wa     = r_rd_idx;
                            end else if (n_free_vld) begin
                                mem_we_key         = 1'b1;
                                mem_we_val         = 1'b1;
                                mem_wa             = n_free_idx;
                                n_used[n_free_idx] = 1'b1;
                                n_count            = r_count + 1'b1;
                            end else begin
                                n_res.status = fskv_pkg::ST_FULL;
                            end
                        end
                        fskv_pkg::FN_GET: begin
                            if (!hit) begin
                                n_res.status = fskv_pkg::ST_NOT_FOUND;
                            end else if ({4'd0, fskv_pkg::packed_len(r_q_val,
                                         fskv_pkg::VALUE_BYTES)} >= r_osize) begin
                                n_res.status = fskv_pkg::ST_TOO_SMALL;
                            end else begin
                                n_res.ret_value = r_q_val;
                            end
                        end
                        fskv_pkg::FN_DELETE: begin
                            if (hit) begin
                                n_used[r_rd_idx] = 1'b0;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end else begin
                                n_res.status = fskv_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_res.status = fskv_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            fskv_pkg::S_ITER: begin
                issuing = r_issue;
                if (issuing) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_rd_vld && r_used[r_rd_idx]) begin
                    n_valid           = 1'b1;
                    n_res.entry_valid = 1'b1;
                    n_res.out_key     = r_q_key;
                    n_res.ret_value   = r_q_val;
                    n_res.last        = !more_used;
                    if (!more_used) begin
                        n_state = fskv_pkg::S_IDLE;
                        n_issue = 1'b0;
                    end
                end
            end

            default: begin
                n_state = fskv_pkg::S_IDLE;
            end
        endcase

        n_res.live_count = n_count;
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for fixed_slot_key_value_table_core: directed and random
// set/get/delete/clear/iterate commands, checked against an in-bench table model.
// Depends on fskv_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int FUNC_CODES = 8;
    localparam int KEY_POOL   = 24;
    localparam int MAX_GAP    = 12;
    localparam int MAX_REPORT = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    fskv_pkg::t_cmd    i_cmd;
    logic              busy;
    logic              o_valid;
    fskv_pkg::t_result o_result;

    fixed_slot_key_value_table_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bench copy of the table
    fskv_pkg::t_word tbl_key [fskv_pkg::SLOTS];
    fskv_pkg::t_word tbl_val [fskv_pkg::SLOTS];
    bit              tbl_used[fskv_pkg::SLOTS];
    int              tbl_count;

    fskv_pkg::t_result replies_due[$];
    int                err_count = 0;
    bit                no_idle   = 1'b0;

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORT) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Length up to the first zero byte, nbytes when unterminated
    function automatic int str_len(input fskv_pkg::t_word w, input int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            if (w[8*i +: 8] == 8'd0) begin
                return i;
            end
        end
        return nbytes;
    endfunction

    function automatic fskv_pkg::t_word str_trim(input fskv_pkg::t_word w, input int len);
        fskv_pkg::t_word r;
        r = '0;
        for (int i = 0; i < len; i++) begin
            r[8*i +: 8] = w[8*i +: 8];
        end
        return r;
    endfunction

    // len nonzero random chars, zero above
    function automatic fskv_pkg::t_word make_str(input int len);
        fskv_pkg::t_word r;
        r = '0;
        for (int i = 0; i < len; i++) begin
            r[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        return r;
    endfunction

    // Random junk past the terminator; must be ignored by the core
    function automatic fskv_pkg::t_word add_tail_junk(input fskv_pkg::t_word w);
        fskv_pkg::t_word r;
        int              len;
        r   = w;
        len = str_len(w, 8);
        for (int i = len + 1; i < 8; i++) begin
            r[8*i +: 8] = 8'($urandom);
        end
        return r;
    endfunction

    function automatic int find_slot(input fskv_pkg::t_word k);
        for (int i = 0; i < fskv_pkg::SLOTS; i++) begin
            if (tbl_used[i] && tbl_key[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < fskv_pkg::SLOTS; i++) begin
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
            tbl_used[i] = 1'b0;
        end
        tbl_count = 0;
    endfunction

    function automatic void push_reply(input fskv_pkg::t_status st, input logic ev,
                                       input fskv_pkg::t_word k, input fskv_pkg::t_word v,
                                       input logic lst);
        fskv_pkg::t_result r;
        r.status      = st;
        r.entry_valid = ev;
        r.out_key     = k;
        r.ret_value   = v;
        r.live_count  = fskv_pkg::CNT_W'(tbl_count);
        r.last        = lst;
        replies_due.push_back(r);
    endfunction

    // Apply one accepted command to the bench table and queue its replies
    function automatic void table_predict(input fskv_pkg::t_cmd c);
        int                klen;
        int                vlen;
        int                idx;
        int                last_used;
        fskv_pkg::t_word   k;
        fskv_pkg::t_word   v;
        fskv_pkg::t_status st;
        fskv_pkg::t_word   rval;
        klen = str_len(c.key, fskv_pkg::KEY_BYTES);
        vlen = str_len(c.value, fskv_pkg::VALUE_BYTES);
        k    = str_trim(c.key, klen);
        v    = str_trim(c.value, vlen);
        st   = fskv_pkg::ST_OK;
        rval = '0;
        case (c.func)
            fskv_pkg::FN_SET: begin
                if (klen >= fskv_pkg::KEY_BYTES || vlen >= fskv_pkg::VALUE_BYTES) begin
                    st = fskv_pkg::ST_INVALID;
                end else begin
                    idx = find_slot(k);
                    if (idx < 0) begin
                        for (int i = 0; i < fskv_pkg::SLOTS; i++) begin
                            if (!tbl_used[i] && idx < 0) begin
                                idx = i;
                            end
                        end
                        if (idx >= 0) begin
                            tbl_key[idx]  = k;
                            tbl_used[idx] = 1'b1;
                            tbl_count++;
                        end
                    end
                    if (idx < 0) begin
                        st = fskv_pkg::ST_FULL;
                    end else begin
                        tbl_val[idx] = v;
                    end
                end
            end
            fskv_pkg::FN_GET: begin
                if (klen >= fskv_pkg::KEY_BYTES || c.buf_size == 8'd0) begin
                    st = fskv_pkg::ST_INVALID;
                end else begin
                    idx = find_slot(k);
                    if (idx < 0) begin
                        st = fskv_pkg::ST_NOT_FOUND;
                    end else if (str_len(tbl_val[idx], fskv_pkg::VALUE_BYTES)
                                 >= int'(c.buf_size)) begin
                        st = fskv_pkg::ST_TOO_SMALL;
                    end else begin
                        rval = tbl_val[idx];
                    end
                end
            end
            fskv_pkg::FN_DELETE: begin
                if (klen >= fskv_pkg::KEY_BYTES) begin
                    st = fskv_pkg::ST_INVALID;
                end else begin
                    idx = find_slot(k);
                    if (idx < 0) begin
                        st = fskv_pkg::ST_NOT_FOUND;
                    end else begin
                        tbl_key[idx]  = '0;
                        tbl_val[idx]  = '0;
                        tbl_used[idx] = 1'b0;
                        if (tbl_count > 0) tbl_count--;
                    end
                end
            end
            fskv_pkg::FN_CLEAR: begin
                table_clear();
            end
            fskv_pkg::FN_ITERATE: begin
                last_used = -1;
                for (int i = 0; i < fskv_pkg::SLOTS; i++) begin
                    if (tbl_used[i]) last_used = i;
                end
                if (last_used < 0) begin
                    push_reply(fskv_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i <= last_used; i++) begin
                        if (tbl_used[i]) begin
                            push_reply(fskv_pkg::ST_OK, 1'b1, tbl_key[i], tbl_val[i],
                                       i == last_used);
                        end
                    end
                end
                return;
            end
            default: begin
                st = fskv_pkg::ST_INVALID;
            end
        endcase
        push_reply(st, 1'b0, '0, rval, 1'b1);
    endfunction

    // One command beat: random idle, then hold start until the core takes it
    task automatic send_cmd(input logic [2:0] fn, input fskv_pkg::t_word key,
                            input fskv_pkg::t_word val, input logic [7:0] osize);
        int             gap;
        fskv_pkg::t_cmd c;
        gap        = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        c.func     = fn;
        c.key      = key;
        c.value    = val;
        c.buf_size = osize;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        table_predict(c);
    endtask

    task automatic check_beat(input fskv_pkg::t_result got);
        fskv_pkg::t_result e;
        if (replies_due.size() == 0) begin
            note_error($sformatf("result beat with nothing expected: st=%0d key=%h val=%h",
                                 got.status, got.out_key, got.ret_value));
            return;
        end
        e = replies_due.pop_front();
        if (got.status !== e.status || got.entry_valid !== e.entry_valid ||
            got.out_key !== e.out_key || got.ret_value !== e.ret_value ||
            got.live_count !== e.live_count || got.last !== e.last) begin
            note_error($sformatf(
                "mismatch exp st=%0d ev=%0d key=%h val=%h cnt=%0d last=%0d",
                e.status, e.entry_valid, e.out_key, e.ret_value, e.live_count, e.last));
            if (err_count <= MAX_REPORT) begin
                $display("         got st=%0d ev=%0d key=%h val=%h cnt=%0d last=%0d",
                         got.status, got.entry_valid, got.out_key, got.ret_value,
                         got.live_count, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            check_beat(o_result);
        end
    end

    task automatic test_empty_table();
        send_cmd(fskv_pkg::FN_ITERATE, '0, '0, 8'd0);
        send_cmd(fskv_pkg::FN_GET, make_str(4), '0, 8'd8);
        send_cmd(fskv_pkg::FN_DELETE, make_str(3), '0, 8'd0);
        send_cmd(fskv_pkg::FN_CLEAR, '0, '0, 8'd0);
    endtask

    task automatic test_field_extremes();
        fskv_pkg::t_word k3;
        k3 = make_str(3);
        send_cmd(fskv_pkg::FN_SET, 64'h00FF_FFFF_FFFF_FFFF, 64'h0001_0101_0101_0101, 8'd0);
        send_cmd(fskv_pkg::FN_SET, '0, '0, 8'd255);
        send_cmd(fskv_pkg::FN_SET, add_tail_junk(k3), add_tail_junk(make_str(2)), 8'd0);
        // seven-char value needs a buffer of eight
        send_cmd(fskv_pkg::FN_GET, 64'h00FF_FFFF_FFFF_FFFF, '0, 8'd7);
        send_cmd(fskv_pkg::FN_GET, 64'h00FF_FFFF_FFFF_FFFF, '0, 8'd8);
        send_cmd(fskv_pkg::FN_GET, k3, '0, 8'd255);
        send_cmd(fskv_pkg::FN_GET, '0, '0, 8'd1);
        send_cmd(fskv_pkg::FN_ITERATE, '0, '0, 8'd0);
    endtask

    task automatic test_invalid_args();
        send_cmd(fskv_pkg::FN_SET, 64'hFFFF_FFFF_FFFF_FFFF, make_str(3), 8'd0);
        send_cmd(fskv_pkg::FN_GET, make_str(8), '0, 8'd255);
        send_cmd(fskv_pkg::FN_DELETE, make_str(8), '0, 8'd0);
        send_cmd(fskv_pkg::FN_SET, make_str(5), make_str(8), 8'd0);
        send_cmd(fskv_pkg::FN_GET, 64'h00FF_FFFF_FFFF_FFFF, '0, 8'd0);
        for (int f = fskv_pkg::FN_ITERATE + 1; f < FUNC_CODES; f++) begin
            send_cmd(3'(f), make_str(2), make_str(2), 8'd4);
        end
    endtask

    task automatic test_overwrite_delete();
        send_cmd(fskv_pkg::FN_SET, 64'h00FF_FFFF_FFFF_FFFF, make_str(6), 8'd0);
        send_cmd(fskv_pkg::FN_GET, 64'h00FF_FFFF_FFFF_FFFF, '0, 8'd255);
        send_cmd(fskv_pkg::FN_DELETE, 64'h00FF_FFFF_FFFF_FFFF, '0, 8'd0);
        send_cmd(fskv_pkg::FN_GET, 64'h00FF_FFFF_FFFF_FFFF, '0, 8'd255);
    endtask

    task automatic test_table_full();
        int n;
        n = 1;
        while (tbl_count < fskv_pkg::SLOTS) begin
            send_cmd(fskv_pkg::FN_SET, fskv_pkg::t_word'({8'(n), 8'h46}),
                     make_str($urandom_range(0, 7)), 8'd0);
            n++;
        end
        send_cmd(fskv_pkg::FN_SET, 64'h5A_5A5A, make_str(4), 8'd0);
        // overwrite still allowed when full
        send_cmd(fskv_pkg::FN_SET, fskv_pkg::t_word'({8'd1, 8'h46}), make_str(7), 8'd0);
        send_cmd(fskv_pkg::FN_ITERATE, '0, '0, 8'd0);
        send_cmd(fskv_pkg::FN_DELETE, fskv_pkg::t_word'({8'd2, 8'h46}), '0, 8'd0);
        send_cmd(fskv_pkg::FN_SET, 64'h5A_5A5A, make_str(4), 8'd0);
        send_cmd(fskv_pkg::FN_CLEAR, '0, '0, 8'd0);
        send_cmd(fskv_pkg::FN_ITERATE, '0, '0, 8'd0);
    endtask

    task automatic test_random_traffic(input int items);
        fskv_pkg::t_word pool[KEY_POOL];
        fskv_pkg::t_word key;
        int              pick;
        logic [7:0]      osize;
        for (int i = 0; i < KEY_POOL; i++) begin
            pool[i] = make_str($urandom_range(0, 7));
        end
        for (int n = 0; n < items; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            key   = add_tail_junk(pool[$urandom_range(0, KEY_POOL - 1)]);
            osize = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
            pick  = $urandom_range(0, 99);
            if (pick < 38) begin
                send_cmd(fskv_pkg::FN_SET, key,
                         add_tail_junk(make_str($urandom_range(0, 7))), osize);
            end else if (pick < 63) begin
                send_cmd(fskv_pkg::FN_GET, key, fskv_pkg::t_word'({$urandom, $urandom}),
                         osize);
            end else if (pick < 78) begin
                send_cmd(fskv_pkg::FN_DELETE, key, '0, osize);
            end else if (pick < 81) begin
                send_cmd(fskv_pkg::FN_CLEAR, key, '0, osize);
            end else if (pick < 89) begin
                send_cmd(fskv_pkg::FN_ITERATE, key, '0, osize);
            end else begin
                case ($urandom_range(0, 3))
                    0: send_cmd(3'($urandom_range(fskv_pkg::FN_SET, fskv_pkg::FN_DELETE)),
                                make_str(8), make_str(3), osize);
                    1: send_cmd(fskv_pkg::FN_SET, key, make_str(8), osize);
                    2: send_cmd(3'($urandom_range(fskv_pkg::FN_ITERATE + 1, FUNC_CODES - 1)),
                                key, make_str(2), osize);
                    default: send_cmd(3'($urandom), fskv_pkg::t_word'({$urandom, $urandom}),
                                      fskv_pkg::t_word'({$urandom, $urandom}), 8'($urandom));
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        table_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_invalid_args();
        test_overwrite_delete();
        test_table_full();
        test_random_traffic(275);

        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (fskv_pkg::SLOTS + 4) @(posedge i_clk);

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("timeout with %0d results still expected", replies_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
